### sv/sot_pkg.sv
package sot_pkg;

   localparam int CAPACITY = 64;
   localparam int KEY_BITS = 32;
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   localparam int ACTION_W = 4;
   localparam int FIELD_W  = 32;
   localparam int POS_W    = 6;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 7;

   typedef logic [KEY_BITS-1:0]       key_type;
   typedef logic signed [FIELD_W-1:0] value_type;
   typedef logic [CNT_W-1:0]          cnt_type;
   typedef logic [ACTION_W-1:0]       action_type;
   typedef logic [STATUS_W-1:0]       status_type;

   localparam action_type ACT_PUT        = 4'd0;
   localparam action_type ACT_GET        = 4'd1;
   localparam action_type ACT_MIN        = 4'd2;
   localparam action_type ACT_MAX        = 4'd3;
   localparam action_type ACT_FLOOR      = 4'd4;
   localparam action_type ACT_CEILING    = 4'd5;
   localparam action_type ACT_RANK       = 4'd6;
   localparam action_type ACT_SELECT     = 4'd7;
   localparam action_type ACT_DELETE_MIN = 4'd8;
   localparam action_type ACT_DELETE_MAX = 4'd9;
   localparam action_type ACT_RANGE      = 4'd10;

   localparam status_type STATUS_OK   = 2'd0;
   localparam status_type STATUS_MISS = 2'd1;
   localparam status_type STATUS_FULL = 2'd2;

   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_WRITE,
      CELL_SHIFT_DOWN,
      CELL_DROP_LAST
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
      logic        cmp;
      key_type     key;
      key_type     upper;
      value_type   value;
   } cell_cmd_type;

   typedef struct packed {
      logic      valid;
      key_type   key;
      value_type value;
   } entry_type;

   function automatic key_type to_key(input logic [FIELD_W-1:0] x);
      logic [63:0] w;
      w = {32'b0, x};
      return w[KEY_BITS-1:0];
   endfunction

   function automatic logic [FIELD_W-1:0] from_key(input key_type k);
      logic [63:0] w;
      w = 64'(k);
      return w[FIELD_W-1:0];
   endfunction

   function automatic logic [COUNT_W-1:0] to_count(input cnt_type c);
      logic [15:0] w;
      w = 16'(c);
      return w[COUNT_W-1:0];
   endfunction

endpackage

### sv/sot_req_if.sv
interface sot_req_if import sot_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [ACTION_W-1:0]     action;
   logic [FIELD_W-1:0]      key;
   logic signed [FIELD_W-1:0] value;
   logic [FIELD_W-1:0]      upper_key;
   logic [POS_W-1:0]        position;

   modport source (output valid, action, key, value, upper_key, position, input ready);
   modport sink   (input valid, action, key, value, upper_key, position, output ready);
endinterface

### sv/sot_rsp_if.sv
interface sot_rsp_if import sot_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [STATUS_W-1:0]       status;
   logic [FIELD_W-1:0]        result_key;
   logic signed [FIELD_W-1:0] result_value;
   logic [COUNT_W-1:0]        result_count;

   modport source (output valid, status, result_key, result_value, result_count,
                   input ready);
   modport sink   (input valid, status, result_key, result_value, result_count,
                   output ready);
endinterface

### sv/sorted_ordered_key_table_core.sv
// Transactions: the cells compare in the accepting cycle (S_IDLE), and the
// boundary encoders and the cell update run in the execute state (S_EXEC);
// the result is registered when the update is done. A new request is taken only
// in S_IDLE, so one transaction is handled at a time. A result still held by the
// receiver keeps the following transaction in S_EXEC until the result is taken.
// Reset (synchronous): empties the table (cell valid bits and occupancy) and
// drops any pending result.
module sorted_ordered_key_table_core import sot_pkg::*; (
   input logic       clock,
   input logic       reset,
   sot_req_if.sink   req_if,
   sot_rsp_if.source rsp_if
);

   typedef enum logic {S_IDLE, S_EXEC} state_type;

   state_type  state_ff, state_in;
   action_type act_ff;
   key_type    key_ff, upper_ff;
   value_type  value_ff;
   logic [POS_W-1:0] pos_ff;
   cnt_type    occ_ff, occ_in;

   logic       out_valid_ff, out_valid_in;
   status_type status_ff, status_in;
   key_type    rkey_ff, rkey_in;
   value_type  rval_ff, rval_in;
   cnt_type    rcnt_ff, rcnt_in;

   logic         accept, done;
   cell_op_type  op;
   cell_cmd_type cmd;

   entry_type ents      [CAPACITY];
   entry_type left_ents [CAPACITY];
   entry_type right_ents[CAPACITY];
   logic      lts       [CAPACITY];
   logic      left_lts  [CAPACITY];
   logic      eqs       [CAPACITY];
   logic      lt_ups    [CAPACITY];

   assign req_if.ready = (state_ff == S_IDLE);
   assign accept       = req_if.valid && req_if.ready;
   assign done         = (state_ff == S_EXEC) && (!out_valid_ff || rsp_if.ready);

   assign cmd.op    = op;
   assign cmd.cmp   = accept;
   assign cmd.key   = accept ? to_key(req_if.key) : key_ff;
   assign cmd.upper = to_key(req_if.upper_key);
   assign cmd.value = value_ff;

   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      if (g == 0) begin : g_head
         assign left_ents[g] = '0;
         assign left_lts[g]  = 1'b1;
      end else begin : g_mid
         assign left_ents[g] = ents[g-1];
         assign left_lts[g]  = lts[g-1];
      end
      if (g == CAPACITY - 1) begin : g_tail
         assign right_ents[g] = '0;
      end else begin : g_body
         assign right_ents[g] = ents[g+1];
      end

      sot_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .cmd       (cmd),
         .left_ent  (left_ents[g]),
         .left_lt   (left_lts[g]),
         .right_ent (right_ents[g]),
         .ent       (ents[g]),
         .lt        (lts[g]),
         .eq        (eqs[g]),
         .lt_up     (lt_ups[g])
      );
   end

   // Reductions over the chain. The lt flags form a thermometer, so the
   // insertion point is where a set flag meets a clear one.
   logic      any_eq;
   cnt_type   idx_k, idx_up, a_idx;
   key_type   key_floor, key_ceil, key_max, key_sel;
   value_type val_eq;
   logic      nxt_lt, nxt_up, nxt_valid, prv_lt;

   always_comb begin
      any_eq    = 1'b0;
      idx_k     = '0;
      idx_up    = '0;
      key_floor = '0;
      key_ceil  = '0;
      key_max   = '0;
      key_sel   = '0;
      val_eq    = '0;
      nxt_lt    = 1'b0;
      nxt_up    = 1'b0;
      nxt_valid = 1'b0;
      prv_lt    = 1'b1;
      for (int i = 0; i < CAPACITY; i++) begin
         nxt_lt    = (i == CAPACITY - 1) ? 1'b0 : lts[(i+1) % CAPACITY];
         nxt_up    = (i == CAPACITY - 1) ? 1'b0 : lt_ups[(i+1) % CAPACITY];
         nxt_valid = (i == CAPACITY - 1) ? 1'b0 : ents[(i+1) % CAPACITY].valid;
         prv_lt    = (i == 0) ? 1'b1 : lts[(i+CAPACITY-1) % CAPACITY];
         if (lts[i] && !nxt_lt) begin
            idx_k     = idx_k | cnt_type'(i + 1);
            key_floor = key_floor | ents[i].key;
         end
         if (lt_ups[i] && !nxt_up) idx_up = idx_up | cnt_type'(i + 1);
         if (ents[i].valid && !lts[i] && prv_lt) key_ceil = key_ceil | ents[i].key;
         if (eqs[i]) begin
            any_eq = 1'b1;
            val_eq = val_eq | ents[i].value;
         end
         if (ents[i].valid && !nxt_valid) key_max = key_max | ents[i].key;
         if (16'(pos_ff) == 16'(i)) key_sel = ents[i].key;
      end
      a_idx = idx_k + cnt_type'(any_eq);
   end

   always_comb begin
      op        = CELL_HOLD;
      occ_in    = occ_ff;
      status_in = STATUS_OK;
      rkey_in   = '0;
      rval_in   = '0;
      rcnt_in   = '0;
      case (act_ff)
         ACT_PUT: begin
            if (any_eq) begin
               op = CELL_WRITE;
            end else if (occ_ff == cnt_type'(CAPACITY)) begin
               status_in = STATUS_FULL;
            end else begin
               op     = CELL_INSERT;
               occ_in = occ_ff + cnt_type'(1);
            end
         end
         ACT_GET: begin
            if (any_eq) rval_in = val_eq;
            else status_in = STATUS_MISS;
         end
         ACT_MIN: begin
            if (occ_ff == '0) status_in = STATUS_MISS;
            else rkey_in = ents[0].key;
         end
         ACT_MAX: begin
            if (occ_ff == '0) status_in = STATUS_MISS;
            else rkey_in = key_max;
         end
         ACT_FLOOR: begin
            if (any_eq) rkey_in = key_ff;
            else if (idx_k != '0) rkey_in = key_floor;
            else status_in = STATUS_MISS;
         end
         ACT_CEILING: begin
            if (idx_k < occ_ff) rkey_in = key_ceil;
            else status_in = STATUS_MISS;
         end
         ACT_RANK: rcnt_in = idx_k;
         ACT_SELECT: begin
            if (16'(pos_ff) < 16'(occ_ff)) rkey_in = key_sel;
            else status_in = STATUS_MISS;
         end
         ACT_DELETE_MIN: begin
            if (occ_ff == '0) begin
               status_in = STATUS_MISS;
            end else begin
               op     = CELL_SHIFT_DOWN;
               occ_in = occ_ff - cnt_type'(1);
            end
         end
         ACT_DELETE_MAX: begin
            if (occ_ff == '0) begin
               status_in = STATUS_MISS;
            end else begin
               op     = CELL_DROP_LAST;
               occ_in = occ_ff - cnt_type'(1);
            end
         end
         ACT_RANGE: begin
            if (key_ff < upper_ff && idx_up > a_idx) rcnt_in = idx_up - a_idx;
         end
         default: status_in = STATUS_MISS;
      endcase
      if (!done) begin
         op     = CELL_HOLD;
         occ_in = occ_ff;
      end
   end

   always_comb begin
      state_in     = state_ff;
      out_valid_in = out_valid_ff;
      if (rsp_if.ready) out_valid_in = 1'b0;
      case (state_ff)
         S_IDLE: if (accept) state_in = S_EXEC;
         S_EXEC: begin
            if (done) begin
               state_in     = S_IDLE;
               out_valid_in = 1'b1;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
         occ_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         occ_ff       <= occ_in;
      end
      if (accept) begin
         act_ff   <= req_if.action;
         key_ff   <= to_key(req_if.key);
         upper_ff <= to_key(req_if.upper_key);
         value_ff <= req_if.value;
         pos_ff   <= req_if.position;
      end
      if (done) begin
         status_ff <= status_in;
         rkey_ff   <= rkey_in;
         rval_ff   <= rval_in;
         rcnt_ff   <= rcnt_in;
      end
   end

   assign rsp_if.valid        = out_valid_ff;
   assign rsp_if.status       = status_ff;
   assign rsp_if.result_key   = from_key(rkey_ff);
   assign rsp_if.result_value = rval_ff;
   assign rsp_if.result_count = to_count(rcnt_ff);

endmodule

### sv/sot_cell.sv
module sot_cell import sot_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  cell_cmd_type cmd,
   input  entry_type    left_ent,
   input  logic         left_lt,
   input  entry_type    right_ent,
   output entry_type    ent,
   output logic         lt,
   output logic         eq,
   output logic         lt_up
);

   logic      valid_ff, valid_in;
   key_type   key_ff, key_in;
   value_type value_ff, value_in;
   logic      lt_ff, lt_in;
   logic      eq_ff, eq_in;
   logic      lt_up_ff, lt_up_in;

   always_comb begin
      valid_in = valid_ff;
      key_in   = key_ff;
      value_in = value_ff;
      lt_in    = lt_ff;
      eq_in    = eq_ff;
      lt_up_in = lt_up_ff;

      if (cmd.cmp) begin
         lt_in    = valid_ff && (key_ff < cmd.key);
         eq_in    = valid_ff && (key_ff == cmd.key);
         lt_up_in = valid_ff && (key_ff < cmd.upper);
      end

      case (cmd.op)
         CELL_INSERT: begin
            // keys below the new one stay; the first cell past them takes it
            if (!lt_ff) begin
               if (left_lt) begin
                  valid_in = 1'b1;
                  key_in   = cmd.key;
                  value_in = cmd.value;
               end else begin
                  valid_in = left_ent.valid;
                  key_in   = left_ent.key;
                  value_in = left_ent.value;
               end
            end
         end
         CELL_WRITE: begin
            if (eq_ff) value_in = cmd.value;
         end
         CELL_SHIFT_DOWN: begin
            valid_in = right_ent.valid;
            key_in   = right_ent.key;
            value_in = right_ent.value;
         end
         CELL_DROP_LAST: begin
            if (valid_ff && !right_ent.valid) valid_in = 1'b0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         lt_ff    <= 1'b0;
         eq_ff    <= 1'b0;
         lt_up_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         lt_ff    <= lt_in;
         eq_ff    <= eq_in;
         lt_up_ff <= lt_up_in;
      end
      key_ff   <= key_in;
      value_ff <= value_in;
   end

   assign ent   = '{valid: valid_ff, key: key_ff, value: value_ff};
   assign lt    = lt_ff;
   assign eq    = eq_ff;
   assign lt_up = lt_up_ff;

endmodule

### tb/sot_table_checker.sv
module sot_table_checker import sot_pkg::*; (
   input  logic clock,
   input  logic reset,
   sot_req_if   req_if,
   sot_rsp_if   rsp_if,
   output int   fail_count,
   output int   pending_count
);

   typedef struct {
      status_type           status;
      logic [FIELD_W-1:0]   key;
      logic [FIELD_W-1:0]   value;
      logic [COUNT_W-1:0]   count;
   } answer_type;

   // shadow of the table, kept sorted ascending
   key_type    table_keys   [CAPACITY];
   value_type  table_values [CAPACITY];
   int         table_fill;
   answer_type expected_answers [$];

   // number of stored keys strictly below k, i.e. the insertion point
   function automatic int count_below(input key_type k);
      int n;
      n = 0;
      for (int i = 0; i < table_fill; i++)
         if (table_keys[i] < k) n++;
      return n;
   endfunction

   function automatic answer_type apply_op(input action_type act, input key_type k,
                                           input value_type v, input key_type up,
                                           input logic [POS_W-1:0] pos);
      answer_type ans;
      int         idx;
      int         hi;
      ans.status = STATUS_OK;
      ans.key    = '0;
      ans.value  = '0;
      ans.count  = '0;
      case (act)
         ACT_PUT: begin
            idx = count_below(k);
            if (idx < table_fill && table_keys[idx] == k) begin
               table_values[idx] = v;
            end else if (table_fill >= CAPACITY) begin
               ans.status = STATUS_FULL;
            end else begin
               for (int i = table_fill; i > idx; i--) begin
                  table_keys[i]   = table_keys[i-1];
                  table_values[i] = table_values[i-1];
               end
               table_keys[idx]   = k;
               table_values[idx] = v;
               table_fill++;
            end
         end
         ACT_GET: begin
            idx = count_below(k);
            if (idx < table_fill && table_keys[idx] == k) ans.value = table_values[idx];
            else ans.status = STATUS_MISS;
         end
         ACT_MIN: begin
            if (table_fill == 0) ans.status = STATUS_MISS;
            else ans.key = FIELD_W'(table_keys[0]);
         end
         ACT_MAX: begin
            if (table_fill == 0) ans.status = STATUS_MISS;
            else ans.key = FIELD_W'(table_keys[table_fill-1]);
         end
         ACT_FLOOR: begin
            idx = count_below(k);
            if (idx < table_fill && table_keys[idx] == k) ans.key = FIELD_W'(k);
            else if (idx > 0) ans.key = FIELD_W'(table_keys[idx-1]);
            else ans.status = STATUS_MISS;
         end
         ACT_CEILING: begin
            idx = count_below(k);
            if (idx < table_fill) ans.key = FIELD_W'(table_keys[idx]);
            else ans.status = STATUS_MISS;
         end
         ACT_RANK: begin
            ans.count = COUNT_W'(count_below(k));
         end
         ACT_SELECT: begin
            if (int'(pos) < table_fill) ans.key = FIELD_W'(table_keys[pos]);
            else ans.status = STATUS_MISS;
         end
         ACT_DELETE_MIN: begin
            if (table_fill == 0) begin
               ans.status = STATUS_MISS;
            end else begin
               for (int i = 0; i < table_fill - 1; i++) begin
                  table_keys[i]   = table_keys[i+1];
                  table_values[i] = table_values[i+1];
               end
               table_fill--;
            end
         end
         ACT_DELETE_MAX: begin
            if (table_fill == 0) ans.status = STATUS_MISS;
            else table_fill--;
         end
         ACT_RANGE: begin
            // open interval: a key equal to the lower bound is not counted
            if (k < up) begin
               idx = count_below(k);
               hi  = count_below(up);
               if (idx < table_fill && table_keys[idx] == k) idx++;
               if (hi > idx) ans.count = COUNT_W'(hi - idx);
            end
         end
         default: begin
            ans.status = STATUS_MISS;
         end
      endcase
      return ans;
   endfunction

   task automatic report_mismatch(input string what, input logic [FIELD_W-1:0] got,
                                  input logic [FIELD_W-1:0] want);
      $display("mismatch on %0s: got %h, expected %h", what, got, want);
      fail_count++;
   endtask

   always @(posedge clock) begin
      answer_type want;
      if (reset) begin
         table_fill = 0;
         expected_answers.delete();
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_answers.size() == 0) begin
               report_mismatch("result with no transaction pending", rsp_if.result_key, '0);
            end else begin
               want = expected_answers.pop_front();
               if (rsp_if.status !== want.status)
                  report_mismatch("status", FIELD_W'(rsp_if.status), FIELD_W'(want.status));
               if (rsp_if.result_key !== want.key)
                  report_mismatch("result_key", rsp_if.result_key, want.key);
               if (rsp_if.result_value !== want.value)
                  report_mismatch("result_value", rsp_if.result_value, want.value);
               if (rsp_if.result_count !== want.count)
                  report_mismatch("result_count", FIELD_W'(rsp_if.result_count),
                                  FIELD_W'(want.count));
            end
         end
         if (req_if.valid && req_if.ready)
            expected_answers.push_back(apply_op(req_if.action, to_key(req_if.key),
                                                req_if.value, to_key(req_if.upper_key),
                                                req_if.position));
      end
      pending_count = expected_answers.size();
   end

endmodule

### tb/sorted_ordered_key_table_core_tb.sv
module sorted_ordered_key_table_core_tb;
   import sot_pkg::*;

   localparam int STALL_LIMIT = 5000;
   localparam int POOL_SIZE   = 48;
   localparam int HOLD_CYCLES = 150;
   localparam int RECENT_MAX  = 128;

   logic clock;
   logic reset;
   int   fail_count;
   int   pending_count;

   sot_req_if req_bus();
   sot_rsp_if rsp_bus();

   sorted_ordered_key_table_core DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus)
   );

   sot_table_checker table_checker (
      .clock         (clock),
      .reset         (reset),
      .req_if        (req_bus),
      .rsp_if        (rsp_bus),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   int      send_idle_pct;
   int      recv_stall_pct;
   int      hold_req;
   int      idle_cycles;
   logic    req_taken;
   key_type key_pool [POOL_SIZE];
   key_type recent_keys [$];

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // acceptance seen at the last rising edge, read back at the falling edge
   always @(posedge clock) req_taken <= req_bus.valid && req_bus.ready && !reset;

   // receiver: random stalls, plus one long hold-off on request
   initial begin
      int hold_seen;
      int hold_left;
      hold_seen = 0;
      hold_left = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready = 1'b0;
         end else begin
            rsp_bus.ready = ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic send_op(input action_type act, input key_type k, input value_type v,
                          input key_type up, input logic [POS_W-1:0] pos);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid = 1'b0;
         @(negedge clock);
      end
      req_bus.action    = act;
      req_bus.key       = from_key(k);
      req_bus.value     = v;
      req_bus.upper_key = from_key(up);
      req_bus.position  = pos;
      req_bus.valid     = 1'b1;
      @(negedge clock);
      while (!req_taken) @(negedge clock);
      if (act == ACT_PUT) begin
         recent_keys.push_back(k);
         if (recent_keys.size() > RECENT_MAX) void'(recent_keys.pop_front());
      end
   endtask

   // mostly keys already stored or near them, so lookups hit
   function automatic key_type pick_key();
      int      choice;
      key_type k;
      choice = $urandom_range(99);
      if (choice < 40 && recent_keys.size() > 0)
         k = recent_keys[$urandom_range(recent_keys.size() - 1)];
      else if (choice < 50 && recent_keys.size() > 0)
         k = recent_keys[$urandom_range(recent_keys.size() - 1)] +
             ($urandom_range(1) ? key_type'(1) : -key_type'(1));
      else if (choice < 80)
         k = key_pool[$urandom_range(POOL_SIZE - 1)];
      else
         k = $urandom;
      return k;
   endfunction

   task automatic random_op(input int put_pct, input int del_pct, input int fresh_pct);
      int         r;
      action_type act;
      key_type    k;
      key_type    up;
      r = $urandom_range(99);
      if (r < put_pct)
         act = ACT_PUT;
      else if (r < put_pct + del_pct)
         act = $urandom_range(1) ? ACT_DELETE_MIN : ACT_DELETE_MAX;
      else if (r >= 97)
         act = action_type'($urandom_range(ACT_RANGE + 1, (1 << ACTION_W) - 1));
      else
         act = action_type'($urandom_range(ACT_GET, ACT_RANGE));
      if (act == ACT_PUT && $urandom_range(99) < fresh_pct) k = $urandom;
      else k = pick_key();
      up = ($urandom_range(3) == 0) ? key_type'($urandom) : pick_key();
      send_op(act, k, $urandom, up, POS_W'($urandom_range(CAPACITY - 1)));
   endtask

   initial begin
      int send_pcts  [4];
      int stall_pcts [4];
      send_pcts  = '{0, 65, 0, 24};
      stall_pcts = '{0, 0, 65, 24};
      reset = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.action    = '0;
      req_bus.key       = '0;
      req_bus.value     = '0;
      req_bus.upper_key = '0;
      req_bus.position  = '0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_req       = 0;
      idle_cycles    = 0;
      key_pool[0] = '0;
      key_pool[1] = '1;
      key_pool[2] = key_type'(1);
      key_pool[3] = key_type'(32'h8000_0000);
      key_pool[4] = key_type'(32'h7FFF_FFFF);
      for (int i = 5; i < POOL_SIZE; i++) key_pool[i] = $urandom;

      repeat (10) @(negedge clock);
      reset = 1'b0;

      // empty table
      send_op(ACT_MIN,        '0, '0, '0, '0);
      send_op(ACT_MAX,        '0, '0, '0, '0);
      send_op(ACT_DELETE_MIN, '0, '0, '0, '0);
      send_op(ACT_DELETE_MAX, '0, '0, '0, '0);
      send_op(ACT_GET,        '0, '0, '0, '0);
      send_op(ACT_FLOOR,      '1, '0, '0, '0);
      send_op(ACT_CEILING,    '0, '0, '0, '0);
      send_op(ACT_SELECT,     '0, '0, '0, '0);
      send_op(ACT_RANK,       '1, '0, '0, '0);
      send_op(ACT_RANGE,      '0, '0, '1, '0);
      // extremes of key and value, then an overwrite
      send_op(ACT_PUT, '0, value_type'(32'h8000_0000), '0, '0);
      send_op(ACT_PUT, '1, value_type'(32'h7FFF_FFFF), '0, '0);
      send_op(ACT_PUT, key_type'(32'h8000_0000), '1, '0, '0);
      send_op(ACT_PUT, '0, value_type'(5), '0, '0);
      send_op(ACT_GET, '0, '0, '0, '0);
      send_op(ACT_GET, '1, '0, '0, '0);
      send_op(ACT_FLOOR,   key_type'(32'h7FFF_FFFF), '0, '0, '0);
      send_op(ACT_CEILING, key_type'(32'h8000_0001), '0, '0, '0);
      send_op(ACT_FLOOR,   '1, '0, '0, '0);
      send_op(ACT_RANK,    '1, '0, '0, '0);
      send_op(ACT_SELECT,  '0, '0, '0, 6'd2);
      send_op(ACT_SELECT,  '0, '0, '0, '1);
      send_op(ACT_RANGE,   '0, '0, '1, '0);
      send_op(ACT_RANGE,   '1, '0, '0, '0);
      send_op(action_type'((1 << ACTION_W) - 1), '1, '1, '1, '1);
      send_op(ACT_DELETE_MIN, '0, '0, '0, '0);
      send_op(ACT_DELETE_MAX, '0, '0, '0, '0);

      for (int phase = 0; phase < 4; phase++) begin
         send_idle_pct  = send_pcts[phase];
         recv_stall_pct = stall_pcts[phase];
         // fill; odd phases use fresh keys only, so the table is bound to fill up
         for (int i = 0; i < 70; i++) random_op(100, 0, (phase % 2) ? 100 : 50);
         if (phase == 0) hold_req++;
         for (int i = 0; i < 64; i++) random_op(25, 10, 20);
         for (int i = 0; i < 40; i++) random_op(5, 70, 0);
      end
      req_bus.valid = 1'b0;

      while (pending_count != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      if (fail_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

### filelist.f
sv/sot_pkg.sv
sv/sot_req_if.sv
sv/sot_rsp_if.sv
sv/sot_cell.sv
sv/sorted_ordered_key_table_core.sv
tb/sot_table_checker.sv
tb/sorted_ordered_key_table_core_tb.sv
